### rtl/vfcs_pkg.sv
// Package for the voxel face cull and shade block: types, codes, palette and shading arithmetic.
package vfcs_pkg;

    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Z_DEF = 16;
    localparam int SIZE_Y_DEF = 128;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] FACE_NEG_X  = 3'd0;
    localparam logic [2:0] FACE_POS_X  = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_NEG_Z  = 3'd4;
    localparam logic [2:0] FACE_POS_Z  = 3'd5;

    localparam logic [3:0] KIND_AIR   = 4'd0;
    localparam logic [3:0] KIND_GRASS = 4'd1;
    localparam logic [3:0] KIND_GLOW  = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_NB,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] face;
        logic [3:0] x;
        logic [6:0] y;
        logic [3:0] z;
    } shade_req_t;

    function automatic color_t mk_color(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a);
        color_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        c.alpha = a;
        return c;
    endfunction

    // Grass uses its own colors on the top and bottom faces.
    function automatic color_t palette_color(input logic [3:0] kind, input logic [2:0] face);
        color_t c;
        case (kind)
            4'd1:    c = mk_color(8'd80, 8'd150, 8'd40, 8'd255);
            4'd2:    c = mk_color(8'd100, 8'd70, 8'd40, 8'd255);
            4'd3:    c = mk_color(8'd120, 8'd120, 8'd120, 8'd255);
            4'd4:    c = mk_color(8'd80, 8'd50, 8'd30, 8'd255);
            4'd5:    c = mk_color(8'd40, 8'd180, 8'd40, 8'd180);
            4'd6:    c = mk_color(8'd220, 8'd200, 8'd120, 8'd255);
            4'd7:    c = mk_color(8'd50, 8'd100, 8'd200, 8'd150);
            4'd8:    c = mk_color(8'd255, 8'd255, 8'd150, 8'd255);
            default: c = mk_color(8'd255, 8'd255, 8'd255, 8'd255);
        endcase
        if (kind == KIND_GRASS && face == FACE_TOP)
        begin
            c = mk_color(8'd100, 8'd200, 8'd50, 8'd255);
        end
        if (kind == KIND_GRASS && face == FACE_BOTTOM)
        begin
            c = mk_color(8'd100, 8'd70, 8'd40, 8'd255);
        end
        return c;
    endfunction

    // Floor of v / 5 by a reciprocal multiply, exact for all 12-bit inputs.
    function automatic logic [9:0] div5(input logic [11:0] v);
        logic [25:0] p;
        p = 26'(v) * 26'd13108;
        return p[25:16];
    endfunction

    // Floor of 255 * j / 100 for a jitter step j of 0 to 9.
    function automatic logic [4:0] jitter_boost(input logic [3:0] j);
        logic [4:0] b;
        case (j)
            4'd0:    b = 5'd0;
            4'd1:    b = 5'd2;
            4'd2:    b = 5'd5;
            4'd3:    b = 5'd7;
            4'd4:    b = 5'd10;
            4'd5:    b = 5'd12;
            4'd6:    b = 5'd15;
            4'd7:    b = 5'd17;
            4'd8:    b = 5'd20;
            4'd9:    b = 5'd22;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

    // Face factor in fifths, then jitter, clamped at full scale.
    function automatic logic [7:0] shade_first(input logic [7:0] base, input logic [2:0] fifths,
                                               input logic [4:0] boost);
        logic [10:0] prod;
        logic [9:0]  c1;
        logic [10:0] sum;
        prod = 11'(base) * 11'(fifths);
        c1   = div5(12'(prod));
        sum  = 11'(c1) + 11'(boost);
        return (sum > 11'd255) ? 8'd255 : sum[7:0];
    endfunction

    // Height gradient in twentieths, clamped at full scale.
    function automatic logic [7:0] shade_second(input logic [7:0] c2, input logic [1:0] ylow);
        logic [12:0] prod;
        logic [9:0]  q;
        prod = 13'(c2) * (13'd18 + 13'(ylow));
        q    = div5(12'(prod[12:2]));
        return (q > 10'd255) ? 8'd255 : q[7:0];
    endfunction

endpackage

### rtl/vfcs_store.sv
// Single-port voxel type memory with a registered read.
module vfcs_store #(
    parameter int DEPTH  = vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF * vfcs_pkg::SIZE_Y_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [3:0]        wdata,
    output logic [3:0]        rdata
);

    logic [3:0] mem [DEPTH];
    logic [3:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/vfcs_shade.sv
// Two-step color shading: face factor and jitter registered, then the height gradient.
module vfcs_shade (
    input  logic                 clk,
    input  logic                 load,
    input  vfcs_pkg::shade_req_t req,
    output vfcs_pkg::color_t     color
);

    vfcs_pkg::color_t pal;
    logic [2:0]       fifths;
    logic [6:0]       mix;
    logic [14:0]      mix_prod;
    logic [3:0]       tens;
    logic [3:0]       jstep;
    logic [4:0]       boost;

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [1:0] ylow_reg;

    always_comb
    begin
        pal = vfcs_pkg::palette_color(req.kind, req.face);
        if (req.kind == vfcs_pkg::KIND_GLOW || req.face == vfcs_pkg::FACE_TOP)
        begin
            fifths = 3'd5;
        end
        else if (req.face == vfcs_pkg::FACE_BOTTOM)
        begin
            fifths = 3'd3;
        end
        else
        begin
            fifths = 3'd4;
        end
        mix      = 7'(req.x) ^ req.y ^ 7'(req.z);
        mix_prod = 15'(mix) * 15'd205;
        tens     = mix_prod[14:11];
        jstep    = 4'(mix - 7'(tens) * 7'd10);
        boost    = vfcs_pkg::jitter_boost(jstep);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= vfcs_pkg::shade_first(pal.red, fifths, boost);
            green_reg <= vfcs_pkg::shade_first(pal.green, fifths, boost);
            blue_reg  <= vfcs_pkg::shade_first(pal.blue, fifths, boost);
            alpha_reg <= pal.alpha;
            ylow_reg  <= req.y[1:0];
        end
    end

    always_comb
    begin
        color.red   = vfcs_pkg::shade_second(red_reg, ylow_reg);
        color.green = vfcs_pkg::shade_second(green_reg, ylow_reg);
        color.blue  = vfcs_pkg::shade_second(blue_reg, ylow_reg);
        color.alpha = alpha_reg;
    end

endmodule

### rtl/voxel_face_cull_shade.sv
// Top level of the voxel face cull and shade block.
// A write request stores a voxel type while the block is idle. A query request reads the
// center voxel when it is accepted and its neighbor in READ_NB, one after the other through
// the single port of the voxel memory, decides visibility in CHECK and loads a visible face
// in FINISH; a query with a coordinate out of range or a face code above five is dropped.
// A finished face waits in an output register while the next request is taken, and the
// block stalls only when a second face is ready before the first has left. The voxel memory
// is not cleared after reset: every voxel must be written before a query reads it.
module voxel_face_cull_shade #(
    parameter int SIZE_X = vfcs_pkg::SIZE_X_DEF,
    parameter int SIZE_Z = vfcs_pkg::SIZE_Z_DEF,
    parameter int SIZE_Y = vfcs_pkg::SIZE_Y_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, pos_z, face_dir, voxel_kind, zero fill
    input  logic [23:0] s_axis_tdata,
    // command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // face_x, face_y, face_z, face_side, red, green, blue, alpha, zero fill
    output logic [55:0] m_axis_tdata
);

    localparam int DEPTH  = SIZE_X * SIZE_Z * SIZE_Y;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STEP_Y = SIZE_X * SIZE_Z;

    vfcs_pkg::state_t state_reg, state_next;

    logic [3:0] in_x;
    logic [6:0] in_y;
    logic [3:0] in_z;
    logic [2:0] in_face;
    logic [3:0] in_kind;
    logic       accept;
    logic       in_range;
    logic [ADDR_W-1:0] in_addr;

    logic [3:0]        x_reg;
    logic [6:0]        y_reg;
    logic [3:0]        z_reg;
    logic [2:0]        face_reg;
    logic [3:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [ADDR_W-1:0] nb_addr;
    logic              at_edge;
    logic              visible;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [3:0]        rd_data;

    logic                 shade_load;
    vfcs_pkg::shade_req_t shade_req;
    vfcs_pkg::color_t     shade_color;

    logic        out_load;
    logic        out_free;
    logic        out_valid_reg, out_valid_next;
    logic [49:0] out_data_reg;

    assign in_x    = s_axis_tdata[3:0];
    assign in_y    = s_axis_tdata[10:4];
    assign in_z    = s_axis_tdata[14:11];
    assign in_face = s_axis_tdata[17:15];
    assign in_kind = s_axis_tdata[21:18];
    assign accept  = s_axis_tvalid & s_axis_tready;

    assign in_range = (32'(in_x) < SIZE_X) && (32'(in_y) < SIZE_Y) && (32'(in_z) < SIZE_Z);
    assign in_addr  = ADDR_W'(in_x) + ADDR_W'(in_z) * ADDR_W'(SIZE_X)
                    + ADDR_W'(in_y) * ADDR_W'(STEP_Y);

    always_comb
    begin
        case (face_reg)
            vfcs_pkg::FACE_NEG_X:
            begin
                at_edge = (x_reg == 4'd0);
                nb_addr = addr_reg - ADDR_W'(1);
            end
            vfcs_pkg::FACE_POS_X:
            begin
                at_edge = (32'(x_reg) == SIZE_X - 1);
                nb_addr = addr_reg + ADDR_W'(1);
            end
            vfcs_pkg::FACE_TOP:
            begin
                at_edge = (32'(y_reg) == SIZE_Y - 1);
                nb_addr = addr_reg + ADDR_W'(STEP_Y);
            end
            vfcs_pkg::FACE_BOTTOM:
            begin
                at_edge = (y_reg == 7'd0);
                nb_addr = addr_reg - ADDR_W'(STEP_Y);
            end
            vfcs_pkg::FACE_NEG_Z:
            begin
                at_edge = (z_reg == 4'd0);
                nb_addr = addr_reg - ADDR_W'(SIZE_X);
            end
            vfcs_pkg::FACE_POS_Z:
            begin
                at_edge = (32'(z_reg) == SIZE_Z - 1);
                nb_addr = addr_reg + ADDR_W'(SIZE_X);
            end
            default:
            begin
                at_edge = 1'b1;
                nb_addr = addr_reg;
            end
        endcase
    end

    assign visible  = (kind_reg != vfcs_pkg::KIND_AIR)
                   && (at_edge || rd_data == vfcs_pkg::KIND_AIR);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vfcs_pkg::ST_IDLE:
            begin
                if (accept && s_axis_tuser == vfcs_pkg::CMD_QUERY && in_range
                    && in_face <= vfcs_pkg::FACE_POS_Z)
                begin
                    state_next = vfcs_pkg::ST_READ_NB;
                end
            end
            vfcs_pkg::ST_READ_NB:
            begin
                state_next = vfcs_pkg::ST_CHECK;
            end
            vfcs_pkg::ST_CHECK:
            begin
                state_next = visible ? vfcs_pkg::ST_FINISH : vfcs_pkg::ST_IDLE;
            end
            vfcs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = vfcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = in_addr;
        shade_load    = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            vfcs_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_we        = s_axis_tvalid && s_axis_tuser == vfcs_pkg::CMD_WRITE
                             && in_range;
            end
            vfcs_pkg::ST_READ_NB:
            begin
                mem_addr = nb_addr;
            end
            vfcs_pkg::ST_CHECK:
            begin
                shade_load = visible;
            end
            vfcs_pkg::ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vfcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            face_reg <= in_face;
            addr_reg <= in_addr;
        end
        if (state_reg == vfcs_pkg::ST_READ_NB)
        begin
            kind_reg <= rd_data;
        end
        if (out_load)
        begin
            out_data_reg <= {shade_color.alpha, shade_color.blue, shade_color.green,
                             shade_color.red, face_reg, z_reg, y_reg, x_reg};
        end
    end

    vfcs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_kind),
        .rdata (rd_data)
    );

    always_comb
    begin
        shade_req.kind = kind_reg;
        shade_req.face = face_reg;
        shade_req.x    = x_reg;
        shade_req.y    = y_reg;
        shade_req.z    = z_reg;
    end

    vfcs_shade u_shade (
        .clk   (clk),
        .load  (shade_load),
        .req   (shade_req),
        .color (shade_color)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

### rtl/vfcs_checker.sv
// Port-level checks for the voxel face cull and shade block, bound to its top level.
module vfcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result request dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Result data changed while stalled.");

    a_write_no_face: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == vfcs_pkg::CMD_WRITE
        |=> !$rose(m_axis_tvalid))
        else $error("A write request produced a face.");

    a_face_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("A face appeared without a query in progress.");

endmodule

bind voxel_face_cull_shade vfcs_checker u_vfcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/face_shade_checker.sv
`timescale 1ns / 100ps
// Checker that tracks the voxel chunk, predicts each visible shaded face and compares results.
module face_shade_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    output int          mismatches,
    output int          faces_due
);

    localparam int CELLS = vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF * vfcs_pkg::SIZE_Y_DEF;

    localparam logic [3:0] KIND_DIRT   = 4'd2;
    localparam logic [3:0] KIND_STONE  = 4'd3;
    localparam logic [3:0] KIND_WOOD   = 4'd4;
    localparam logic [3:0] KIND_LEAVES = 4'd5;
    localparam logic [3:0] KIND_SAND   = 4'd6;
    localparam logic [3:0] KIND_WATER  = 4'd7;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    typedef struct packed {
        logic [3:0] x;
        logic [6:0] y;
        logic [3:0] z;
        logic [2:0] side;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } face_t;

    logic [3:0] chunk [0:CELLS-1];
    face_t      due_faces [$];

    initial
    begin
        mismatches = 0;
        faces_due  = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            chunk[i] = vfcs_pkg::KIND_AIR;
        end
    end

    task automatic report(input string what, input int got_v, input int want_v);
        $display("face mismatch in %s: got %0d, expected %0d", what, got_v, want_v);
        mismatches++;
    endtask

    function automatic int cell_index(input int x, input int y, input int z);
        return x + z * vfcs_pkg::SIZE_X_DEF + y * vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF;
    endfunction

    function automatic rgba_t base_color(input logic [3:0] kind, input logic [2:0] side);
        rgba_t c;
        case (kind)
            vfcs_pkg::KIND_GRASS: c = '{8'd80, 8'd150, 8'd40, 8'd255};
            KIND_DIRT:            c = '{8'd100, 8'd70, 8'd40, 8'd255};
            KIND_STONE:           c = '{8'd120, 8'd120, 8'd120, 8'd255};
            KIND_WOOD:            c = '{8'd80, 8'd50, 8'd30, 8'd255};
            KIND_LEAVES:          c = '{8'd40, 8'd180, 8'd40, 8'd180};
            KIND_SAND:            c = '{8'd220, 8'd200, 8'd120, 8'd255};
            KIND_WATER:           c = '{8'd50, 8'd100, 8'd200, 8'd150};
            vfcs_pkg::KIND_GLOW:  c = '{8'd255, 8'd255, 8'd150, 8'd255};
            default:              c = '{8'd255, 8'd255, 8'd255, 8'd255};
        endcase
        if (kind == vfcs_pkg::KIND_GRASS && side == vfcs_pkg::FACE_TOP)
        begin
            c = '{8'd100, 8'd200, 8'd50, 8'd255};
        end
        if (kind == vfcs_pkg::KIND_GRASS && side == vfcs_pkg::FACE_BOTTOM)
        begin
            c = '{8'd100, 8'd70, 8'd40, 8'd255};
        end
        return c;
    endfunction

    function automatic logic [7:0] tone(input int base, input int fifths, input int jit,
                                        input int grad);
        int c;
        c = (base * fifths) / 5;
        c = c + (255 * jit) / 100;
        if (c > 255)
        begin
            c = 255;
        end
        c = (c * grad) / 20;
        if (c > 255)
        begin
            c = 255;
        end
        return c[7:0];
    endfunction

    function automatic bit predict_face(input logic [3:0] x, input logic [6:0] y,
                                        input logic [3:0] z, input logic [2:0] side,
                                        output face_t f);
        logic [3:0] kind;
        bit         on_rim;
        int         nb;
        rgba_t      col;
        int         fifths;
        int         jit;
        int         grad;
        f      = '0;
        on_rim = 1'b0;
        nb     = 0;
        if (side > vfcs_pkg::FACE_POS_Z)
        begin
            return 1'b0;
        end
        kind = chunk[cell_index(x, y, z)];
        if (kind == vfcs_pkg::KIND_AIR)
        begin
            return 1'b0;
        end
        case (side)
            vfcs_pkg::FACE_NEG_X:
            begin
                on_rim = (x == 0);
                if (!on_rim) nb = cell_index(int'(x) - 1, y, z);
            end
            vfcs_pkg::FACE_POS_X:
            begin
                on_rim = (x == vfcs_pkg::SIZE_X_DEF - 1);
                if (!on_rim) nb = cell_index(int'(x) + 1, y, z);
            end
            vfcs_pkg::FACE_TOP:
            begin
                on_rim = (y == vfcs_pkg::SIZE_Y_DEF - 1);
                if (!on_rim) nb = cell_index(x, int'(y) + 1, z);
            end
            vfcs_pkg::FACE_BOTTOM:
            begin
                on_rim = (y == 0);
                if (!on_rim) nb = cell_index(x, int'(y) - 1, z);
            end
            vfcs_pkg::FACE_NEG_Z:
            begin
                on_rim = (z == 0);
                if (!on_rim) nb = cell_index(x, y, int'(z) - 1);
            end
            default:
            begin
                on_rim = (z == vfcs_pkg::SIZE_Z_DEF - 1);
                if (!on_rim) nb = cell_index(x, y, int'(z) + 1);
            end
        endcase
        if (!on_rim && chunk[nb] != vfcs_pkg::KIND_AIR)
        begin
            return 1'b0;
        end
        col    = base_color(kind, side);
        fifths = 4;
        if (side == vfcs_pkg::FACE_TOP) fifths = 5;
        if (side == vfcs_pkg::FACE_BOTTOM) fifths = 3;
        if (kind == vfcs_pkg::KIND_GLOW) fifths = 5;
        jit  = int'(x ^ y ^ z) % 10;
        grad = 18 + int'(y[1:0]);
        f.x     = x;
        f.y     = y;
        f.z     = z;
        f.side  = side;
        f.red   = tone(col.r, fifths, jit, grad);
        f.green = tone(col.g, fifths, jit, grad);
        f.blue  = tone(col.b, fifths, jit, grad);
        f.alpha = col.a;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        face_t      want;
        face_t      got;
        logic [3:0] rx;
        logic [6:0] ry;
        logic [3:0] rz;
        logic [2:0] rside;
        logic [3:0] rkind;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x     = m_axis_tdata[3:0];
                got.y     = m_axis_tdata[10:4];
                got.z     = m_axis_tdata[14:11];
                got.side  = m_axis_tdata[17:15];
                got.red   = m_axis_tdata[25:18];
                got.green = m_axis_tdata[33:26];
                got.blue  = m_axis_tdata[41:34];
                got.alpha = m_axis_tdata[49:42];
                if (due_faces.size() == 0)
                begin
                    report("face with nothing expected, side", got.side, -1);
                end
                else
                begin
                    want = due_faces.pop_front();
                    if (got.x != want.x) report("face_x", got.x, want.x);
                    if (got.y != want.y) report("face_y", got.y, want.y);
                    if (got.z != want.z) report("face_z", got.z, want.z);
                    if (got.side != want.side) report("face_side", got.side, want.side);
                    if (got.red != want.red) report("red", got.red, want.red);
                    if (got.green != want.green) report("green", got.green, want.green);
                    if (got.blue != want.blue) report("blue", got.blue, want.blue);
                    if (got.alpha != want.alpha) report("alpha", got.alpha, want.alpha);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rx    = s_axis_tdata[3:0];
                ry    = s_axis_tdata[10:4];
                rz    = s_axis_tdata[14:11];
                rside = s_axis_tdata[17:15];
                rkind = s_axis_tdata[21:18];
                if (s_axis_tuser == vfcs_pkg::CMD_WRITE)
                begin
                    chunk[cell_index(rx, ry, rz)] = rkind;
                end
                else if (predict_face(rx, ry, rz, rside, want))
                begin
                    due_faces.push_back(want);
                end
            end
            faces_due <= due_faces.size();
        end
    end

endmodule

### tb/tb_voxel_face_cull_shade.sv
`timescale 1ns / 100ps
// Testbench top for the voxel face cull and shade block: stimulus, flow control and verdict.
module tb_voxel_face_cull_shade;

    localparam int CELLS           = vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF
                                   * vfcs_pkg::SIZE_Y_DEF;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_CYCLES     = 250;
    localparam int RANDOM_REQUESTS = 500;

    localparam logic [3:0] KIND_STONE   = 4'd3;
    localparam logic [3:0] KIND_WATER   = 4'd7;
    localparam logic [3:0] KIND_UNNAMED = 4'd15;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    int mismatches;
    int faces_due;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_wanted   = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int requests_sent = 0;

    bit written_map [0:CELLS-1];
    int written_cells [$];

    initial
    begin
        forever #2 clk = ~clk;
    end

    voxel_face_cull_shade dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    face_shade_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .faces_due     (faces_due)
    );

    always @(negedge clk)
    begin
        if (hold_wanted && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("voxel_face_cull_shade: mismatch");
            $finish;
        end
    end

    function automatic int cell_of(input int x, input int y, input int z);
        return x + z * vfcs_pkg::SIZE_X_DEF + y * vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF;
    endfunction

    task automatic send(input logic cmd, input logic [3:0] x, input logic [6:0] y,
                        input logic [3:0] z, input logic [2:0] side, input logic [3:0] kind);
        int gap;
        int idx;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, kind, side, z, y, x};
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
        idx = cell_of(x, y, z);
        if (cmd == vfcs_pkg::CMD_WRITE && !written_map[idx])
        begin
            written_map[idx] = 1'b1;
            written_cells.push_back(idx);
        end
    endtask

    task automatic write_cell(input int x, input int y, input int z, input logic [3:0] kind);
        send(vfcs_pkg::CMD_WRITE, 4'(x), 7'(y), 4'(z), 3'($urandom_range(7)), kind);
    endtask

    task automatic query_cell(input int x, input int y, input int z, input logic [2:0] side);
        send(vfcs_pkg::CMD_QUERY, 4'(x), 7'(y), 4'(z), side, 4'($urandom_range(15)));
    endtask

    function automatic int rand_span(input int top_val);
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return top_val;
        return $urandom_range(top_val);
    endfunction

    function automatic logic [3:0] rand_kind();
        if ($urandom_range(99) < 30) return vfcs_pkg::KIND_AIR;
        return 4'($urandom_range(15));
    endfunction

    // A query names a voxel already written; an unwritten neighbor is written first.
    task automatic random_step();
        int         pick;
        int         cx;
        int         cy;
        int         cz;
        int         nx;
        int         ny;
        int         nz;
        logic [2:0] side;
        bit         on_rim;
        if (written_cells.size() == 0 || $urandom_range(99) < 35)
        begin
            write_cell(rand_span(vfcs_pkg::SIZE_X_DEF - 1), rand_span(vfcs_pkg::SIZE_Y_DEF - 1),
                       rand_span(vfcs_pkg::SIZE_Z_DEF - 1), rand_kind());
        end
        else
        begin
            pick = written_cells[$urandom_range(written_cells.size() - 1)];
            cx   = pick % vfcs_pkg::SIZE_X_DEF;
            cz   = (pick / vfcs_pkg::SIZE_X_DEF) % vfcs_pkg::SIZE_Z_DEF;
            cy   = pick / (vfcs_pkg::SIZE_X_DEF * vfcs_pkg::SIZE_Z_DEF);
            if ($urandom_range(99) < 8)
            begin
                side = vfcs_pkg::FACE_POS_Z + 3'(1 + $urandom_range(1));
            end
            else
            begin
                side = 3'($urandom_range(vfcs_pkg::FACE_POS_Z));
            end
            nx = cx;
            ny = cy;
            nz = cz;
            case (side)
                vfcs_pkg::FACE_NEG_X:
                begin
                    on_rim = (cx == 0);
                    nx     = cx - 1;
                end
                vfcs_pkg::FACE_POS_X:
                begin
                    on_rim = (cx == vfcs_pkg::SIZE_X_DEF - 1);
                    nx     = cx + 1;
                end
                vfcs_pkg::FACE_TOP:
                begin
                    on_rim = (cy == vfcs_pkg::SIZE_Y_DEF - 1);
                    ny     = cy + 1;
                end
                vfcs_pkg::FACE_BOTTOM:
                begin
                    on_rim = (cy == 0);
                    ny     = cy - 1;
                end
                vfcs_pkg::FACE_NEG_Z:
                begin
                    on_rim = (cz == 0);
                    nz     = cz - 1;
                end
                vfcs_pkg::FACE_POS_Z:
                begin
                    on_rim = (cz == vfcs_pkg::SIZE_Z_DEF - 1);
                    nz     = cz + 1;
                end
                default: on_rim = 1'b1;
            endcase
            if (!on_rim && (!written_map[cell_of(nx, ny, nz)] || $urandom_range(99) < 25))
            begin
                write_cell(nx, ny, nz,
                           $urandom_range(1) ? vfcs_pkg::KIND_AIR : 4'($urandom_range(15)));
            end
            query_cell(cx, cy, cz, side);
        end
    endtask

    initial
    begin : stimulus
        int goal;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_cell(0, 0, 0, vfcs_pkg::KIND_GRASS);
        query_cell(0, 0, 0, vfcs_pkg::FACE_NEG_X);
        query_cell(0, 0, 0, vfcs_pkg::FACE_BOTTOM);
        query_cell(0, 0, 0, vfcs_pkg::FACE_NEG_Z);
        write_cell(15, 127, 15, vfcs_pkg::KIND_GLOW);
        query_cell(15, 127, 15, vfcs_pkg::FACE_POS_X);
        query_cell(15, 127, 15, vfcs_pkg::FACE_TOP);
        query_cell(15, 127, 15, vfcs_pkg::FACE_POS_Z);
        write_cell(1, 0, 0, vfcs_pkg::KIND_AIR);
        query_cell(0, 0, 0, vfcs_pkg::FACE_POS_X);
        write_cell(0, 1, 0, KIND_STONE);
        query_cell(0, 0, 0, vfcs_pkg::FACE_TOP);
        query_cell(0, 1, 0, vfcs_pkg::FACE_BOTTOM);
        query_cell(0, 1, 0, vfcs_pkg::FACE_NEG_X);
        query_cell(0, 0, 0, vfcs_pkg::FACE_POS_Z + 3'd1);
        query_cell(0, 0, 0, vfcs_pkg::FACE_POS_Z + 3'd2);
        write_cell(1, 0, 0, KIND_UNNAMED);
        query_cell(1, 0, 0, vfcs_pkg::FACE_NEG_X);
        query_cell(1, 0, 0, vfcs_pkg::FACE_BOTTOM);
        write_cell(15, 127, 15, vfcs_pkg::KIND_AIR);
        query_cell(15, 127, 15, vfcs_pkg::FACE_TOP);
        write_cell(15, 127, 15, KIND_WATER);
        query_cell(15, 127, 15, vfcs_pkg::FACE_TOP);
        write_cell(3, 127, 9, vfcs_pkg::KIND_GRASS);
        query_cell(3, 127, 9, vfcs_pkg::FACE_TOP);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_wanted   = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default:
                begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase
            goal = requests_sent + RANDOM_REQUESTS / 4;
            while (requests_sent < goal)
            begin
                random_step();
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (faces_due != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("voxel_face_cull_shade: match");
        end
        else
        begin
            $display("voxel_face_cull_shade: mismatch");
        end
        $finish;
    end

endmodule

### files.f
rtl/vfcs_pkg.sv
rtl/vfcs_store.sv
rtl/vfcs_shade.sv
rtl/voxel_face_cull_shade.sv
rtl/vfcs_checker.sv
tb/face_shade_checker.sv
tb/tb_voxel_face_cull_shade.sv
